[hdl/cmsr_pkg.sv]
// ----------------------------------------------------------------------------
// cmsr_pkg
// Shared widths, defaults and helpers for the corner-min square rotation block.
// ----------------------------------------------------------------------------
package cmsr_pkg;

  // Payload and configuration widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIM_W       = 4;

  // Default largest side length and reset value of the dimension register
  localparam int unsigned MAX_DIM_DEF = 8;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  // Clamp the programmed dimension into 1..max_dim
  function automatic logic [DIM_W-1:0] side_len(logic [DIM_W-1:0] dim,
                                               int unsigned max_dim);
    logic [DIM_W-1:0] n;
    n = dim;
    if (n == '0) begin
      n = DIM_W'(1);
    end
    if (n > DIM_W'(max_dim)) begin
      n = DIM_W'(max_dim);
    end
    return n;
  endfunction

endpackage

[hdl/corner_min_square_rotation.sv]
// ----------------------------------------------------------------------------
// corner_min_square_rotation
// Loads an n-by-n matrix, rotates it so the smallest corner lands top-left,
// and streams the rotated matrix out in row-major order.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_valid_i/ready_o    cfg_dimension_i (side length)
//   in       in         in_valid_i/ready_o     element_value_i
//   out      out        out_valid_o/ready_i    out_value_o, row_end_o, last_o
//
// Loading takes one beat per cycle; each element is written to the store.
// After the completing beat, input ready stays low while the four corners
// are scanned through the registered store read port and the n*n reads
// follow, one per cycle while the output does not stall. Read data still held
// from the previous matrix delays the corner scan until it moves to the output.
// Output beats leave at one per cycle while out_ready_i stays high; a stall
// holds the read stage and the output register and pauses further reads.
// The store has no reset and no clearing pass; reset clears only control.
// ----------------------------------------------------------------------------
module corner_min_square_rotation #(
  parameter int unsigned MAX_DIM = cmsr_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cmsr_pkg::DIM_W-1:0]  cfg_dimension_i,
  // input elements
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cmsr_pkg::DATA_W-1:0] element_value_i,
  // rotated output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cmsr_pkg::DATA_W-1:0] out_value_o,
  output logic                        row_end_o,
  output logic                        last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [cmsr_pkg::DIM_W-1:0]  dimension_q;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [cmsr_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  // Dimension register, written whenever a config beat arrives
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q <= cmsr_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dimension_q <= cfg_dimension_i;
    end
  end

  cmsr_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dimension_i     (dimension_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_value_o     (out_value_o),
    .row_end_o       (row_end_o),
    .last_o          (last_o)
  );

  cmsr_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (cmsr_pkg::DATA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[hdl/cmsr_store.sv]
// ----------------------------------------------------------------------------
// cmsr_store
// Matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmsr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write on request; hold read data unless a read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cmsr_ctrl.sv]
// ----------------------------------------------------------------------------
// cmsr_ctrl
// Load counter, corner scan, rotation address generation and output stages.
// ----------------------------------------------------------------------------
module cmsr_ctrl #(
  parameter int unsigned MAX_DIM = cmsr_pkg::MAX_DIM_DEF,
  parameter int unsigned AW      = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cmsr_pkg::DIM_W-1:0]  dimension_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cmsr_pkg::DATA_W-1:0] element_value_i,
  // store ports
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [cmsr_pkg::DATA_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [cmsr_pkg::DATA_W-1:0] mem_rdata_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cmsr_pkg::DATA_W-1:0] out_value_o,
  output logic                        row_end_o,
  output logic                        last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned NW    = $clog2(MAX_DIM + 1);
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [2:0]  CK_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_CORNER = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    ROT_NONE,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_e;

  state_e                      state_q, state_d;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [NW-1:0]               n_q, n_d;
  logic [2:0]                  ck_q, ck_d;
  logic [cmsr_pkg::DATA_W-1:0] lo_q, lo_d;
  rot_e                        rot_q, rot_d;
  logic [IW-1:0]               r_q, r_d, c_q, c_d;
  logic                        s1_vld_q, s1_vld_d;
  logic                        s1_row_end_q, s1_row_end_d;
  logic                        s1_last_q, s1_last_d;
  logic                        out_vld_q, out_vld_d;
  logic [cmsr_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic                        out_row_end_q, out_row_end_d;
  logic                        out_last_q, out_last_d;

  logic [NW-1:0] n_cur;
  logic [CW-1:0] total, cnt_p1;
  logic [IW-1:0] m;
  logic          in_acc, load_done;
  logic          s1_adv, emit_issue, corner_step, corner_issue;
  logic [IW-1:0] ra, ca;
  logic [CW-1:0] raddr_full;
  logic          at_row_end, at_last;

  // Side length and element count for the load in progress
  assign n_cur     = NW'(cmsr_pkg::side_len(dimension_i, MAX_DIM));
  assign total     = CW'(n_cur) * CW'(n_cur);
  assign cnt_p1    = CW'(cnt_q) + CW'(1);
  assign m         = IW'(n_q - NW'(1));

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_done  = in_acc && (cnt_p1 >= total);

  // Store write port follows the load counter
  assign mem_we_o    = in_acc;
  assign mem_waddr_o = cnt_q;
  assign mem_wdata_o = element_value_i;

  // Read issue: stage one moves on when the output register frees up
  assign s1_adv       = s1_vld_q && (!out_vld_q || out_ready_i);
  assign emit_issue   = (state_q == ST_EMIT) && (!s1_vld_q || s1_adv);
  assign corner_step  = (state_q == ST_CORNER) && !s1_vld_q;
  assign corner_issue = corner_step && (ck_q != CK_LAST);
  assign mem_re_o     = corner_issue || emit_issue;

  assign at_row_end = (c_q == m);
  assign at_last    = (r_q == m) && at_row_end;

  // Pick the stored row and column to read
  always_comb begin
    ra = '0;
    ca = '0;
    if (state_q == ST_CORNER) begin
      // scan order: top-left, bottom-right, bottom-left, top-right
      case (ck_q)
        3'd1: begin
          ra = m;
          ca = m;
        end
        3'd2: begin
          ra = m;
        end
        3'd3: begin
          ca = m;
        end
        default: begin
          ra = '0;
          ca = '0;
        end
      endcase
    end else begin
      case (rot_q)
        ROT_270: begin
          ra = c_q;
          ca = m - r_q;
        end
        ROT_90: begin
          ra = m - c_q;
          ca = r_q;
        end
        ROT_180: begin
          ra = m - r_q;
          ca = m - c_q;
        end
        default: begin
          ra = r_q;
          ca = c_q;
        end
      endcase
    end
  end

  assign raddr_full  = CW'(ra) * CW'(n_q) + CW'(ca);
  assign mem_raddr_o = AW'(raddr_full);

  // Sequencer: load, scan corners, emit
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    ck_d    = ck_q;
    lo_d    = lo_q;
    rot_d   = rot_q;
    r_d     = r_q;
    c_d     = c_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_done) begin
            cnt_d   = '0;
            n_d     = n_cur;
            ck_d    = '0;
            state_d = ST_CORNER;
          end else begin
            cnt_d = AW'(cnt_p1);
          end
        end
      end
      ST_CORNER: begin
        if (corner_step) begin
          // later corners win ties, giving top-right the highest priority
          case (ck_q)
            3'd1: begin
              lo_d  = mem_rdata_i;
              rot_d = ROT_NONE;
            end
            3'd2: begin
              if (mem_rdata_i <= lo_q) begin
                lo_d  = mem_rdata_i;
                rot_d = ROT_180;
              end
            end
            3'd3: begin
              if (mem_rdata_i <= lo_q) begin
                lo_d  = mem_rdata_i;
                rot_d = ROT_90;
              end
            end
            3'd4: begin
              if (mem_rdata_i <= lo_q) begin
                lo_d  = mem_rdata_i;
                rot_d = ROT_270;
              end
            end
            default: begin
              lo_d = lo_q;
            end
          endcase
          if (ck_q == CK_LAST) begin
            r_d     = '0;
            c_d     = '0;
            state_d = ST_EMIT;
          end else begin
            ck_d = ck_q + 3'd1;
          end
        end
      end
      ST_EMIT: begin
        if (emit_issue) begin
          if (at_row_end) begin
            c_d = '0;
            r_d = r_q + IW'(1);
          end else begin
            c_d = c_q + IW'(1);
          end
          if (at_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Stage one (store read data) and output register
  always_comb begin
    s1_vld_d      = s1_vld_q;
    s1_row_end_d  = s1_row_end_q;
    s1_last_d     = s1_last_q;
    out_vld_d     = out_vld_q;
    out_data_d    = out_data_q;
    out_row_end_d = out_row_end_q;
    out_last_d    = out_last_q;
    if (emit_issue) begin
      s1_vld_d     = 1'b1;
      s1_row_end_d = at_row_end;
      s1_last_d    = at_last;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    if (s1_adv) begin
      out_vld_d     = 1'b1;
      out_data_d    = mem_rdata_i;
      out_row_end_d = s1_row_end_q;
      out_last_d    = s1_last_q;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      ck_q      <= '0;
      r_q       <= '0;
      c_q       <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ck_q      <= ck_d;
      r_q       <= r_d;
      c_q       <= c_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    lo_q          <= lo_d;
    rot_q         <= rot_d;
    s1_row_end_q  <= s1_row_end_d;
    s1_last_q     <= s1_last_d;
    out_data_q    <= out_data_d;
    out_row_end_q <= out_row_end_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_data_q;
  assign row_end_o   = out_row_end_q;
  assign last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  // A completing beat restarts the counter and enters the corner scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_done |=> (state_q == ST_CORNER) && (cnt_q == '0))
    else $error("load completion did not start corner scan");

  // Corner reads must not overwrite undelivered read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CORNER) && mem_re_o) |-> !s1_vld_q)
    else $error("corner read clobbered pending read data");

  // The final element always closes a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> out_row_end_q)
    else $error("last beat without row end");

  // Read data moved forward is shown on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("advanced read data lost");
`endif

endmodule
